// ===== src/mbiq_pkg.sv =====
// Shared types and constants for the multichannel biquad filter.
`timescale 1ns / 1ps

package mbiq_pkg;

  localparam int NumChannels = 8;

  localparam int ChanW   = 3;
  localparam int SampleW = 24;
  localparam int CoefW   = 32;
  localparam int ModeW   = 2;
  localparam int FracW   = 26;
  localparam int CfgIdxW = 3;

  localparam int ProdW = CoefW + SampleW;
  localparam int AccW  = ProdW + 3;
  localparam int QW    = AccW - FracW;

  typedef logic [ChanW-1:0]          chan_t;
  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;

  localparam logic [ModeW-1:0] ModeFilter = 2'd0;
  localparam logic [ModeW-1:0] ModeSilent = 2'd1;
  localparam logic [ModeW-1:0] ModePass   = 2'd2;

  localparam logic [CfgIdxW-1:0] RegCoefB0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefB1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefB2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefA1 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefA2 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMode   = 3'd5;

  // Unity gain in Q6.26.
  localparam coef_t CoefOne = 32'sd67108864;

  localparam sample_t SampleMax = 24'sh7fffff;
  localparam sample_t SampleMin = 24'sh800000;

endpackage

// ===== src/multichannel_biquad_iir_filter.sv =====
// Top level of the multichannel direct form I biquad filter.
//
// One input beat carries a Q1.23 sample in s_axis_tdata and its channel number
// in s_axis_tuser. Each channel keeps its own two past inputs and two past
// outputs. The result beat carries the rounded, saturated Q1.23 output on
// m_axis_tdata and echoes the channel on m_axis_tuser.
// Coefficients (Q6.26) and the output mode are written through the cfg port
// while the stream is idle, a user rule the block does not enforce. The mode
// selects filtering, silence or pass-through. A beat taken in enters the input
// register; then the five multiplies, the sum and the rounding feed the result
// register and, in filtering mode, the channel history in the same cycle.
// Throughput is one beat per clock when not stalled, also for back-to-back
// beats on the same channel, as the history is written at the edge that loads
// the result. Reset clears the pipeline, all channel histories, sets b0 to
// 1.0, the other coefficients to zero and the mode to filtering. When the
// receiver stalls, the result is held and one more beat waits in the input
// register; after that s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps

module multichannel_biquad_iir_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [mbiq_pkg::SampleW-1:0] s_axis_tdata,  // [23:0] sample_in
  input  logic [mbiq_pkg::ChanW-1:0]   s_axis_tuser,  // [2:0] channel_in
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [mbiq_pkg::SampleW-1:0] m_axis_tdata,  // [23:0] sample_out
  output logic [mbiq_pkg::ChanW-1:0]   m_axis_tuser,  // [2:0] channel_out
  input  logic                         cfg_we_i,
  input  logic [mbiq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mbiq_pkg::CoefW-1:0]   cfg_data_i
);
  import mbiq_pkg::*;

  // Configuration registers.
  coef_t            b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [ModeW-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q   <= CoefOne;
      b1_q   <= '0;
      b2_q   <= '0;
      a1_q   <= '0;
      a2_q   <= '0;
      mode_q <= ModeFilter;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCoefB0: b0_q   <= coef_t'(cfg_data_i);
        RegCoefB1: b1_q   <= coef_t'(cfg_data_i);
        RegCoefB2: b2_q   <= coef_t'(cfg_data_i);
        RegCoefA1: a1_q   <= coef_t'(cfg_data_i);
        RegCoefA2: a2_q   <= coef_t'(cfg_data_i);
        RegMode:   mode_q <= cfg_data_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // Input register and result register handshake.
  logic    in_vld_q, out_vld_q;
  chan_t   in_ch_q, out_ch_q;
  sample_t in_x_q, out_y_q;
  logic    in_move;

  assign in_move       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || in_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (in_move) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q <= s_axis_tuser;
      in_x_q  <= sample_t'(s_axis_tdata);
    end
  end

  // Per-channel history.
  sample_t x1_q [NumChannels];
  sample_t x2_q [NumChannels];
  sample_t y1_q [NumChannels];
  sample_t y2_q [NumChannels];

  logic    ch_ok;
  sample_t x1, x2, y1, y2;

  assign ch_ok = (32'(in_ch_q) < NumChannels);
  assign x1    = x1_q[in_ch_q];
  assign x2    = x2_q[in_ch_q];
  assign y1    = y1_q[in_ch_q];
  assign y2    = y2_q[in_ch_q];

  // Filter arithmetic: exact Q7.49 products, exact sum, round half up, saturate.
  logic signed [ProdW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [AccW-1:0]  acc, acc_rnd;
  logic signed [QW-1:0]    q;
  sample_t                 y_sat, y_sel;

  always_comb begin
    p_b0    = b0_q * in_x_q;
    p_b1    = b1_q * x1;
    p_b2    = b2_q * x2;
    p_a1    = a1_q * y1;
    p_a2    = a2_q * y2;
    acc     = AccW'(p_b0) + AccW'(p_b1) + AccW'(p_b2) - AccW'(p_a1) - AccW'(p_a2);
    acc_rnd = acc + (AccW'(1) <<< (FracW - 1));
    q       = acc_rnd[AccW-1:FracW];
    if (q > QW'(SampleMax)) begin
      y_sat = SampleMax;
    end else if (q < QW'(SampleMin)) begin
      y_sat = SampleMin;
    end else begin
      y_sat = q[SampleW-1:0];
    end
    if (!ch_ok) begin
      y_sel = '0;
    end else begin
      case (mode_q)
        ModeFilter: y_sel = y_sat;
        ModePass:   y_sel = in_x_q;
        default:    y_sel = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChannels; c++) begin
        x1_q[c] <= '0;
        x2_q[c] <= '0;
        y1_q[c] <= '0;
        y2_q[c] <= '0;
      end
    end else if (in_move && ch_ok && (mode_q == ModeFilter)) begin
      x2_q[in_ch_q] <= x1;
      x1_q[in_ch_q] <= in_x_q;
      y2_q[in_ch_q] <= y1;
      y1_q[in_ch_q] <= y_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_move) begin
      out_ch_q <= in_ch_q;
      out_y_q  <= y_sel;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_y_q;
  assign m_axis_tuser  = out_ch_q;

endmodule

// ===== src/mbiq_checker.sv =====
// Port-level checks for the biquad filter, bound to its top level.
`timescale 1ns / 1ps

module mbiq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [mbiq_pkg::SampleW-1:0] m_axis_tdata,
  input logic [mbiq_pkg::ChanW-1:0]   m_axis_tuser
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A ready receiver never blocks the input side.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the receiver is ready");

  // With a free receiver a taken beat comes out through the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result beat missing after two cycles");

  // A new result only follows an input beat that passed the input register.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result beat without an input beat");

endmodule

bind multichannel_biquad_iir_filter mbiq_checker u_mbiq_checker (.*);
